[src/twp_pkg.sv]
// Shared types and constants for the two-level weighted picker.
// Holds command and result formats, kind and status codes, field widths.
// No dependencies.
package twp_pkg;

  // Fixed field widths
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned ROLL_W   = 16;

  // Entries in the command queue between front and back end
  localparam int unsigned CMD_Q_DEPTH = 2;

  // Input word kinds
  typedef enum logic [1:0] {
    KIND_WR_TIER  = 2'd0,
    KIND_WR_ROW   = 2'd1,
    KIND_SET_TYPE = 2'd2,
    KIND_PICK     = 2'd3
  } kind_e;

  // Pick status codes
  localparam logic [1:0] STATUS_NONE = 2'd0;
  localparam logic [1:0] STATUS_TIER = 2'd1;
  localparam logic [1:0] STATUS_ROW  = 2'd2;

  // Classified command handed from front to back end
  typedef struct packed {
    kind_e                 kind;
    logic [2:0]            tier_index;
    logic [3:0]            row_index;
    logic [3:0]            tier_type;
    logic [WEIGHT_W-1:0]   weight;
    logic [4:0]            row_count;
    logic [ROLL_W-1:0]     roll_tier;
    logic [ROLL_W-1:0]     roll_row;
  } cmd_t;

  // Pick result
  typedef struct packed {
    logic [3:0] chosen_row;
    logic [2:0] chosen_tier;
    logic [1:0] pick_status;
  } res_t;

endpackage

[src/twp_front.sv]
// Front end of the picker: unpacks input words, drops writes that address
// nothing and saturates row counts, then hands commands to the queue.
// Depends on twp_pkg.
module twp_front
  import twp_pkg::*;
#(
  parameter int unsigned MAX_TIERS = 8,
  parameter int unsigned MAX_ROWS  = 16
) (
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        q_full_i,
  output logic        q_push_o,
  output cmd_t        q_cmd_o
);

  logic tier_ok;
  logic row_ok;
  logic keep;
  cmd_t cmd;

  // Unpack the word
  always_comb begin
    cmd.kind       = kind_e'(s_axis_tuser);
    cmd.tier_index = s_axis_tdata[2:0];
    cmd.row_index  = s_axis_tdata[6:3];
    cmd.tier_type  = s_axis_tdata[10:7];
    cmd.weight     = s_axis_tdata[26:11];
    cmd.roll_tier  = s_axis_tdata[47:32];
    cmd.roll_row   = s_axis_tdata[63:48];
    // Store row counts saturated to the row capacity
    if (32'(s_axis_tdata[31:27]) > MAX_ROWS) begin
      cmd.row_count = 5'(MAX_ROWS);
    end else begin
      cmd.row_count = s_axis_tdata[31:27];
    end
  end

  // Classify: drop writes outside the tables
  always_comb begin
    tier_ok = 32'(cmd.tier_index) < MAX_TIERS;
    row_ok  = 32'(cmd.row_index) < MAX_ROWS;
    case (cmd.kind)
      KIND_WR_TIER:  keep = tier_ok;
      KIND_WR_ROW:   keep = tier_ok && row_ok;
      KIND_SET_TYPE: keep = 1'b1;
      KIND_PICK:     keep = 1'b1;
      default:       keep = 1'b0;
    endcase
  end

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i && keep;
  assign q_cmd_o       = cmd;

endmodule

[src/twp_cmd_fifo.sv]
// Short command queue between front and back end of the picker.
// Two entries; lets either side stall on its own. Depends on twp_pkg.
module twp_cmd_fifo
  import twp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t cmd_o
);

  localparam int unsigned PW = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CMD_Q_DEPTH + 1);

  cmd_t          mem_q [CMD_Q_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push;
  logic          do_pop;

  assign full_o  = count_q == CW'(CMD_Q_DEPTH);
  assign valid_o = count_q != '0;
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == CMD_Q_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == CMD_Q_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold queued words
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[src/twp_back.sv]
// Back end of the picker: tier and row tables, the tier count register and
// the sequencer that runs writes, set-by-type sweeps and picks.
// Depends on twp_pkg.
module twp_back
  import twp_pkg::*;
#(
  parameter int unsigned MAX_TIERS = 8,
  parameter int unsigned MAX_ROWS  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output res_t       res_o
);

  localparam int unsigned TIW = (MAX_TIERS > 1) ? $clog2(MAX_TIERS) : 1;
  localparam int unsigned TCW = $clog2(MAX_TIERS + 1);
  localparam int unsigned RCW = $clog2(MAX_ROWS + 1);
  localparam int unsigned ENT = MAX_TIERS * MAX_ROWS;
  localparam int unsigned AW  = (ENT > 1) ? $clog2(ENT) : 1;
  localparam int unsigned TSW = WEIGHT_W + TCW;
  localparam int unsigned RSW = WEIGHT_W + RCW;
  localparam int unsigned TPW = ROLL_W + TSW;
  localparam int unsigned RPW = ROLL_W + RSW;

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_TYPE  = 4'd1;
  localparam logic [3:0] ST_TSUM  = 4'd2;
  localparam logic [3:0] ST_TMUL  = 4'd3;
  localparam logic [3:0] ST_TWALK = 4'd4;
  localparam logic [3:0] ST_RSUM  = 4'd5;
  localparam logic [3:0] ST_RMUL  = 4'd6;
  localparam logic [3:0] ST_RWALK = 4'd7;
  localparam logic [3:0] ST_RES   = 4'd8;

  // Tables
  logic [WEIGHT_W-1:0] tw_q [MAX_TIERS];
  logic [3:0]          ty_q [MAX_TIERS];
  logic [4:0]          tr_q [MAX_TIERS];
  logic [WEIGHT_W-1:0] row_mem [ENT];

  logic [3:0]          tier_count_q;
  logic [3:0]          state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [TCW-1:0]      idx_q, idx_d;
  logic [TSW-1:0]      tot_q, tot_d;
  logic [TCW-1:0]      ctier_q, ctier_d;
  logic [RCW-1:0]      m_q, m_d;
  logic [RCW-1:0]      ra_q, ra_d;
  logic [RCW-1:0]      wi_q, wi_d;
  logic [RSW-1:0]      rtot_q, rtot_d;
  logic                rvld_q, rvld_d;
  logic [WEIGHT_W-1:0] rdata_q;
  res_t                pres_q, pres_d;
  logic                out_valid_q, out_valid_d;
  res_t                out_q, out_d;

  logic [TCW-1:0]      n_used;
  logic [WEIGHT_W-1:0] w_cur;
  logic [TPW-1:0]      tprod;
  logic [RPW-1:0]      rprod;
  logic                tier_we;
  logic                set_we;
  logic                mem_we;
  logic                mem_re;
  logic [AW-1:0]       mem_waddr;
  logic [AW-1:0]       mem_raddr;
  logic                issue;

  // Effective tier count, saturated to the table size
  assign n_used = (32'(tier_count_q) > MAX_TIERS) ? TCW'(MAX_TIERS) : TCW'(tier_count_q);
  assign w_cur  = tw_q[idx_q[TIW-1:0]];
  assign tprod  = TPW'(cmd_q.roll_tier) * TPW'(tot_q);
  assign rprod  = RPW'(cmd_q.roll_row) * RPW'(rtot_q);
  assign mem_waddr = AW'(32'(cmd_i.tier_index) * MAX_ROWS + 32'(cmd_i.row_index));
  assign mem_raddr = AW'(32'(ctier_q) * MAX_ROWS + 32'(ra_q));
  assign issue     = (state_q == ST_RSUM || state_q == ST_RWALK) && (ra_q < m_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    tot_d       = tot_q;
    ctier_d     = ctier_q;
    m_d         = m_q;
    ra_d        = ra_q;
    wi_d        = wi_q;
    rtot_d      = rtot_q;
    rvld_d      = 1'b0;
    pres_d      = pres_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    tier_we     = 1'b0;
    set_we      = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    // Drop the result once taken
    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Row reads are registered: each is issued in the cycle before its data is used
    if (issue) begin
      mem_re = 1'b1;
      ra_d   = ra_q + 1'b1;
      rvld_d = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          idx_d     = '0;
          tot_d     = '0;
          case (cmd_i.kind)
            KIND_WR_TIER:  tier_we = 1'b1;
            KIND_WR_ROW:   mem_we  = 1'b1;
            KIND_SET_TYPE: state_d = ST_TYPE;
            KIND_PICK: begin
              if (n_used == '0) begin
                pres_d  = '{chosen_row: '0, chosen_tier: '0, pick_status: STATUS_NONE};
                state_d = ST_RES;
              end else begin
                state_d = ST_TSUM;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      // Sweep the tiers in use, rewriting those of the matching type
      ST_TYPE: begin
        if (idx_q < n_used) begin
          set_we = ty_q[idx_q[TIW-1:0]] == cmd_q.tier_type;
          idx_d  = idx_q + 1'b1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_TSUM: begin
        if (idx_q < n_used) begin
          tot_d = tot_q + TSW'(w_cur);
          idx_d = idx_q + 1'b1;
        end else begin
          state_d = ST_TMUL;
        end
      end
      // Scale the tier roll by the total
      ST_TMUL: begin
        tot_d   = tprod[ROLL_W +: TSW];
        idx_d   = '0;
        state_d = ST_TWALK;
      end
      ST_TWALK: begin
        if (idx_q < n_used) begin
          if (tot_q <= TSW'(w_cur)) begin
            ctier_d = idx_q;
            m_d     = RCW'(tr_q[idx_q[TIW-1:0]]);
            rtot_d  = '0;
            ra_d    = '0;
            wi_d    = '0;
            state_d = ST_RSUM;
          end else begin
            tot_d = tot_q - TSW'(w_cur);
            idx_d = idx_q + 1'b1;
          end
        end else begin
          pres_d  = '{chosen_row: '0, chosen_tier: '0, pick_status: STATUS_NONE};
          state_d = ST_RES;
        end
      end
      ST_RSUM: begin
        if (rvld_q) begin
          rtot_d = rtot_q + RSW'(rdata_q);
        end else if (!(ra_q < m_q)) begin
          state_d = ST_RMUL;
        end
      end
      // Scale the row roll by the row total
      ST_RMUL: begin
        rtot_d  = rprod[ROLL_W +: RSW];
        ra_d    = '0;
        wi_d    = '0;
        state_d = ST_RWALK;
      end
      ST_RWALK: begin
        if (rvld_q) begin
          if (rtot_q < RSW'(rdata_q)) begin
            pres_d  = '{chosen_row: 4'(wi_q), chosen_tier: 3'(ctier_q),
                        pick_status: STATUS_ROW};
            state_d = ST_RES;
          end else begin
            rtot_d = rtot_q - RSW'(rdata_q);
            wi_d   = wi_q + 1'b1;
          end
        end else if (!(ra_q < m_q)) begin
          pres_d  = '{chosen_row: '0, chosen_tier: 3'(ctier_q), pick_status: STATUS_TIER};
          state_d = ST_RES;
        end
      end
      // Hand the result to the output register when it is free
      ST_RES: begin
        if (!out_valid_q || res_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = pres_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tier_count_q <= '0;
      rvld_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      rvld_q      <= rvld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        tier_count_q <= cfg_wdata_i;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    idx_q   <= idx_d;
    tot_q   <= tot_d;
    ctier_q <= ctier_d;
    m_q     <= m_d;
    ra_q    <= ra_d;
    wi_q    <= wi_d;
    rtot_q  <= rtot_d;
    pres_q  <= pres_d;
    out_q   <= out_d;
  end

  // Tier table writes
  always_ff @(posedge clk_i) begin
    if (tier_we) begin
      tw_q[TIW'(cmd_i.tier_index)] <= cmd_i.weight;
      ty_q[TIW'(cmd_i.tier_index)] <= cmd_i.tier_type;
      tr_q[TIW'(cmd_i.tier_index)] <= cmd_i.row_count;
    end
    if (set_we) begin
      tw_q[idx_q[TIW-1:0]] <= cmd_q.weight;
    end
  end

  // Row weight memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= cmd_i.weight;
    end
    if (mem_re) begin
      rdata_q <= row_mem[mem_raddr];
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

[src/two_level_weighted_picker_core.sv]
// Two-level roulette-wheel picker. A pick first chooses a tier in proportion
// to its weight, then a row of that tier in proportion to the row weight.
// Tier and row writes are made as the back end takes the word from the queue;
// a set-by-type word sweeps the n tiers in use at one per cycle. In a pick,
// the tier sum and tier walk step through the tier table one entry per cycle,
// and the row sum and row walk step through the row weight memory one entry
// per cycle behind its single registered read port. A two-word command queue
// lets the input keep accepting while the back end works, until the queue
// fills, and the result register holds a pick result until it is taken.
// Write the tier count only while the block is idle. Depends on twp_pkg.
module two_level_weighted_picker_core
  import twp_pkg::*;
#(
  parameter int unsigned MAX_TIERS = 8,
  parameter int unsigned MAX_ROWS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,    // tier_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tier_index[2:0], row_index[6:3], tier_type[10:7], weight[26:11],
  // row_count[31:27], roll_tier[47:32], roll_row[63:48]
  input  logic [63:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pick_status[1:0], chosen_tier[4:2], chosen_row[8:5], zeros above
  output logic [15:0] m_axis_tdata
);

  logic q_full;
  logic q_push;
  cmd_t q_in;
  logic q_valid;
  logic q_pop;
  cmd_t q_out;
  res_t res;

  twp_front #(
    .MAX_TIERS(MAX_TIERS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (q_in)
  );

  twp_cmd_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_in),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .cmd_o  (q_out)
  );

  twp_back #(
    .MAX_TIERS(MAX_TIERS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_valid_i(q_valid),
    .cmd_i      (q_out),
    .cmd_pop_o  (q_pop),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res)
  );

  // Pack the result word
  assign m_axis_tdata = {7'd0, res.chosen_row, res.chosen_tier, res.pick_status};

endmodule

[src/twp_checker.sv]
// Port-level checks for the two-level weighted picker, bound to the top.
// Depends on twp_pkg and two_level_weighted_picker_core.
module twp_checker
  import twp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Only defined status codes leave the block
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] == STATUS_NONE ||
                       m_axis_tdata[1:0] == STATUS_TIER ||
                       m_axis_tdata[1:0] == STATUS_ROW))
    else $error("undefined pick status");

  // Indices are zero where the status says none was chosen
  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != STATUS_ROW |->
      m_axis_tdata[8:5] == 4'd0 &&
      (m_axis_tdata[1:0] != STATUS_NONE || m_axis_tdata[4:2] == 3'd0))
    else $error("index set without a matching status");

  // Padding bits stay clear
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:9] == 7'd0)
    else $error("padding bits set in result word");

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid on leaving reset");

endmodule

bind two_level_weighted_picker_core twp_checker u_twp_checker (.*);

[bench/tb.sv]
// Self-checking bench for two_level_weighted_picker_core.
// Drives command words and tier-count writes, predicts each pick and compares
// it with the result stream. Depends on twp_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb;
  import twp_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned NUM_PHASES    = 9;
  localparam int unsigned PHASE_WORDS   = 170;
  localparam int unsigned PRESSURE_PH   = 4;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned TIERS         = 8;
  localparam int unsigned ROWS          = 16;

  typedef struct {
    logic       is_cfg;
    logic [3:0] cfg_val;
    cmd_t       cmd;
    logic       typed;
    res_t       want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [3:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // tier_index, row_index, tier_type, weight,
                               // row_count, roll_tier, roll_row
  logic [1:0]  s_axis_tuser;   // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // pick_status, chosen_tier, chosen_row

  // Shadow copy of the picker tables and the tier count
  logic [15:0] tier_wt   [TIERS];
  logic [3:0]  tier_ty   [TIERS];
  logic [4:0]  tier_rows [TIERS];
  logic [15:0] row_wt    [TIERS*ROWS];
  logic [3:0]  tier_count_q;

  res_t        pending_picks[$];
  int unsigned src_idle;
  int unsigned sink_stall;
  int unsigned hold_left;
  int unsigned words_sent;
  int unsigned picks_checked;
  int unsigned mismatches;
  res_t        got_res;
  res_t        exp_res;

  int unsigned phase_count [NUM_PHASES] = '{8, 15, 1, 5, 8, 0, 2, 7, 8};
  int unsigned phase_src   [NUM_PHASES] = '{0, 77, 0, 9, 0, 77, 0, 9, 0};
  int unsigned phase_sink  [NUM_PHASES] = '{0, 0, 77, 9, 0, 0, 77, 9, 0};

  two_level_weighted_picker_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Two-stage roulette pick over the shadow tables
  function automatic res_t roulette_pick(input cmd_t c);
    res_t              r;
    int unsigned       n;
    int unsigned       m;
    int unsigned       sel;
    logic              found;
    longint unsigned   total;
    longint unsigned   roll;
    int                i;
    r     = '0;
    n     = (tier_count_q > TIERS) ? TIERS : tier_count_q;
    total = 0;
    sel   = 0;
    found = 1'b0;
    if (n == 0) return r;
    for (i = 0; i < n; i++) total += tier_wt[i];
    roll = (longint'(c.roll_tier) * total) >> ROLL_W;
    for (i = 0; i < n; i++) begin
      if (!found) begin
        if (roll <= tier_wt[i]) begin
          sel   = i;
          found = 1'b1;
        end else begin
          roll -= tier_wt[i];
        end
      end
    end
    if (!found) return r;
    r.pick_status = STATUS_TIER;
    r.chosen_tier = sel[2:0];
    m     = tier_rows[sel];
    total = 0;
    for (i = 0; i < m; i++) total += row_wt[sel*ROWS + i];
    roll  = (longint'(c.roll_row) * total) >> ROLL_W;
    found = 1'b0;
    for (i = 0; i < m; i++) begin
      if (!found) begin
        if (roll < row_wt[sel*ROWS + i]) begin
          r.pick_status = STATUS_ROW;
          r.chosen_row  = i[3:0];
          found         = 1'b1;
        end else begin
          roll -= row_wt[sel*ROWS + i];
        end
      end
    end
    return r;
  endfunction

  // Update the shadow tables for one accepted word, queue a pick result
  task automatic apply_word(input cmd_t c, input logic typed, input res_t want);
    int unsigned n;
    int          i;
    n = (tier_count_q > TIERS) ? TIERS : tier_count_q;
    case (c.kind)
      KIND_WR_TIER: begin
        tier_wt[c.tier_index]   = c.weight;
        tier_ty[c.tier_index]   = c.tier_type;
        tier_rows[c.tier_index] = (c.row_count > ROWS) ? 5'(ROWS) : c.row_count;
      end
      KIND_WR_ROW: row_wt[c.tier_index*ROWS + c.row_index] = c.weight;
      KIND_SET_TYPE: begin
        for (i = 0; i < n; i++)
          if (tier_ty[i] == c.tier_type) tier_wt[i] = c.weight;
      end
      default: pending_picks.push_back(typed ? want : roulette_pick(c));
    endcase
  endtask

  function automatic cmd_t word(input kind_e k, input int ti, input int ri, input int ty,
                                input int w, input int rc, input int rt, input int rr);
    cmd_t c;
    c.kind       = k;
    c.tier_index = 3'(ti);
    c.row_index  = 4'(ri);
    c.tier_type  = 4'(ty);
    c.weight     = 16'(w);
    c.row_count  = 5'(rc);
    c.roll_tier  = 16'(rt);
    c.roll_row   = 16'(rr);
    return c;
  endfunction

  function automatic res_t outcome(input logic [1:0] st, input int tier, input int row);
    res_t r;
    r.pick_status = st;
    r.chosen_tier = 3'(tier);
    r.chosen_row  = 4'(row);
    return r;
  endfunction

  // Weights and rolls lean on zero and full scale
  function automatic int rand_wide();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 16'hFFFF;
      2:       return $urandom_range(15);
      default: return $urandom_range(16'hFFFF);
    endcase
  endfunction

  function automatic cmd_t rand_word();
    cmd_t        c;
    int unsigned sel;
    int          rc;
    int          ty;
    sel = $urandom_range(99);
    rc  = ($urandom_range(9) == 0) ? $urandom_range(31, 17) :
          ($urandom_range(9) == 0) ? 0 : $urandom_range(16, 1);
    ty  = ($urandom_range(9) < 6) ? $urandom_range(3) : $urandom_range(15);
    c   = word(KIND_PICK, $urandom_range(7), $urandom_range(15), ty, rand_wide(), rc,
               rand_wide(), rand_wide());
    if (sel < 15)      c.kind = KIND_WR_TIER;
    else if (sel < 43) c.kind = KIND_WR_ROW;
    else if (sel < 55) c.kind = KIND_SET_TYPE;
    return c;
  endfunction

  // Offer one word, hold it until accepted
  task automatic send_word(input cmd_t c, input logic typed, input res_t want);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = c.kind;
    s_axis_tdata  = {c.roll_row, c.roll_tier, c.row_count, c.weight,
                     c.tier_type, c.row_index, c.tier_index};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_word(c, typed, want);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic await_results();
    s_axis_tvalid = 1'b0;
    while (pending_picks.size() != 0) @(negedge clk_i);
  endtask

  // Drain, let non-result words finish, then write the tier count
  task automatic set_tier_count(input logic [3:0] v);
    await_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_wdata_i = v;
    cfg_we_i    = 1'b1;
    @(posedge clk_i);
    tier_count_q = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Receiver: long hold-off when asked, else random stalls
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= sink_stall);
    end
  end

  // Compare each taken result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = res_t'(m_axis_tdata[8:0]);
      if (pending_picks.size() == 0) begin
        $display("%0t: unexpected result, got status %0d tier %0d row %0d", $time,
                 got_res.pick_status, got_res.chosen_tier, got_res.chosen_row);
        mismatches++;
      end else begin
        exp_res = pending_picks.pop_front();
        check_field("pick_status", exp_res.pick_status, got_res.pick_status);
        check_field("chosen_tier", exp_res.chosen_tier, got_res.chosen_tier);
        check_field("chosen_row", exp_res.chosen_row, got_res.chosen_row);
        picks_checked++;
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycles,
             pending_picks.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    dir_row_t    dir_tab[$];
    dir_row_t    row;
    res_t        none;
    int          i;
    int unsigned p;
    int unsigned k;
    none          = '0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_WR_TIER;
    m_axis_tready = 1'b1;
    src_idle      = 0;
    sink_stall    = 0;
    hold_left     = 0;
    words_sent    = 0;
    picks_checked = 0;
    mismatches    = 0;
    tier_count_q  = '0;

    // Directed rows: reset state, saturation, zero weights, extremes
    row = '{1'b0, 4'd0, word(KIND_PICK, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            outcome(STATUS_NONE, 0, 0)};
    dir_tab.push_back(row);
    row.cmd = word(KIND_PICK, 7, 15, 15, 16'hFFFF, 31, 16'hFFFF, 16'hFFFF);
    dir_tab.push_back(row);
    row = '{1'b0, 4'd0, word(KIND_SET_TYPE, 0, 0, 0, 16'hFFFF, 0, 0, 0), 1'b0, none};
    dir_tab.push_back(row);
    row = '{1'b1, 4'd1, word(KIND_PICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, none};
    dir_tab.push_back(row);
    row = '{1'b0, 4'd0, word(KIND_WR_TIER, 0, 0, 5, 0, 0, 0, 0), 1'b0, none};
    dir_tab.push_back(row);
    // all tier weights zero and no rows: first tier, no row
    row = '{1'b0, 4'd0, word(KIND_PICK, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF), 1'b1,
            outcome(STATUS_TIER, 0, 0)};
    dir_tab.push_back(row);
    row = '{1'b0, 4'd0, word(KIND_WR_ROW, 0, 0, 0, 0, 0, 0, 0), 1'b0, none};
    dir_tab.push_back(row);
    row = '{1'b0, 4'd0, word(KIND_WR_TIER, 0, 0, 5, 0, 1, 0, 0), 1'b0, none};
    dir_tab.push_back(row);
    // one row of zero weight
    row = '{1'b0, 4'd0, word(KIND_PICK, 0, 0, 0, 0, 0, 0, 16'hFFFF), 1'b1,
            outcome(STATUS_TIER, 0, 0)};
    dir_tab.push_back(row);
    row = '{1'b0, 4'd0, word(KIND_WR_ROW, 0, 0, 0, 16'hFFFF, 0, 0, 0), 1'b0, none};
    dir_tab.push_back(row);
    row = '{1'b0, 4'd0, word(KIND_PICK, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF), 1'b1,
            outcome(STATUS_ROW, 0, 0)};
    dir_tab.push_back(row);
    // row count above the limit saturates
    row = '{1'b0, 4'd0, word(KIND_WR_TIER, 0, 0, 5, 7, 31, 0, 0), 1'b0, none};
    dir_tab.push_back(row);
    row = '{1'b0, 4'd0, word(KIND_PICK, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            outcome(STATUS_ROW, 0, 0)};
    dir_tab.push_back(row);
    // tier count above the limit saturates
    row = '{1'b1, 4'd15, word(KIND_PICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, none};
    dir_tab.push_back(row);
    row = '{1'b0, 4'd0, word(KIND_WR_TIER, 7, 0, 15, 16'hFFFF, 16, 0, 0), 1'b0, none};
    dir_tab.push_back(row);
    row.cmd = word(KIND_WR_ROW, 7, 15, 0, 16'hFFFF, 0, 0, 0);
    dir_tab.push_back(row);
    row.cmd = word(KIND_PICK, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF);
    dir_tab.push_back(row);
    row.cmd = word(KIND_SET_TYPE, 0, 0, 5, 16'hFFFF, 0, 0, 0);
    dir_tab.push_back(row);
    row = '{1'b0, 4'd0, word(KIND_PICK, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            outcome(STATUS_ROW, 0, 0)};
    dir_tab.push_back(row);
    row = '{1'b0, 4'd0, word(KIND_PICK, 0, 0, 0, 0, 0, 16'h8000, 16'h8000), 1'b0, none};
    dir_tab.push_back(row);
    row.cmd = word(KIND_SET_TYPE, 0, 0, 15, 0, 0, 0, 0);
    dir_tab.push_back(row);
    row.cmd = word(KIND_PICK, 0, 0, 0, 0, 0, 16'hFFFF, 0);
    dir_tab.push_back(row);
    row = '{1'b1, 4'd0, word(KIND_PICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, none};
    dir_tab.push_back(row);
    row = '{1'b0, 4'd0, word(KIND_PICK, 0, 0, 0, 0, 0, 16'h1234, 16'h4321), 1'b1,
            outcome(STATUS_NONE, 0, 0)};
    dir_tab.push_back(row);

    // Reset
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Fill every table entry so no pick reads an unwritten one
    for (i = 0; i < TIERS; i++) begin
      row.cmd = rand_word();
      row.cmd.kind       = KIND_WR_TIER;
      row.cmd.tier_index = 3'(i);
      send_word(row.cmd, 1'b0, none);
    end
    for (i = 0; i < TIERS*ROWS; i++) begin
      row.cmd = rand_word();
      row.cmd.kind       = KIND_WR_ROW;
      row.cmd.tier_index = 3'(i / ROWS);
      row.cmd.row_index  = 4'(i % ROWS);
      send_word(row.cmd, 1'b0, none);
    end

    // Walk the directed table
    foreach (dir_tab[j]) begin
      if (dir_tab[j].is_cfg) set_tier_count(dir_tab[j].cfg_val);
      else send_word(dir_tab[j].cmd, dir_tab[j].typed, dir_tab[j].want);
    end

    // Random phases, each with its own tier count and idle pattern
    for (p = 0; p < NUM_PHASES; p++) begin
      set_tier_count(4'(phase_count[p]));
      src_idle   = phase_src[p];
      sink_stall = phase_sink[p];
      // hold the receiver off so the input backs up
      if (p == PRESSURE_PH) hold_left = HOLD_CYCLES;
      for (k = 0; k < PHASE_WORDS; k++) begin
        // pause the sender until all results are home
        if (p == PRESSURE_PH && k == PHASE_WORDS / 2) await_results();
        send_word(rand_word(), 1'b0, none);
      end
    end

    await_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("Run covered %0d words over %0d tier-count settings and", words_sent,
             NUM_PHASES + 3);
    $display("compared %0d pick results under mixed sender and receiver idling",
             picks_checked);
    if (mismatches == 0 && pending_picks.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
